[design/esa_pkg.sv]
// types, constants and helpers shared by the encoder setpoint accelerator
`default_nettype none
package esa_pkg;

	localparam int NUM_KNOBS   = 2;
	localparam int COUNT_WIDTH = 8;

	localparam int VAL_W      = 14;
	localparam int THR_W      = 10;
	localparam int KSPD_W     = 10;
	localparam int TGT_W      = 2;
	localparam int STEP_W     = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_THRESHOLD    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MAX          = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MAX         = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_START_VALUE = 2'd3;

	localparam logic [THR_W-1:0] RST_FAST_THRESHOLD    = 10'd60;
	localparam logic [VAL_W-1:0] RST_TEMP_MAX          = 14'd3000;
	localparam logic [VAL_W-1:0] RST_SPEED_MAX         = 14'd1500;
	localparam logic [VAL_W-1:0] RST_SPEED_START_VALUE = 14'd200;

	// request and knob codes
	localparam logic REQ_EDGE   = 1'b0;
	localparam logic REQ_TICK   = 1'b1;
	localparam logic KNOB_TEMP  = 1'b0;
	localparam logic KNOB_SPEED = 1'b1;

	localparam logic [TGT_W-1:0] EDIT_NONE  = 2'd0;
	localparam logic [TGT_W-1:0] EDIT_TEMP  = 2'd1;
	localparam logic [TGT_W-1:0] EDIT_SPEED = 2'd2;

	localparam logic [STEP_W-1:0] STEP_FINE   = 5'd10;
	localparam logic [STEP_W-1:0] STEP_COARSE = 5'd30;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = {COUNT_WIDTH{1'b1}};
	localparam logic [KSPD_W-1:0]      SPEED_LIMIT = {KSPD_W{1'b1}};

	// edges per window scaled to edges per minute
	localparam int MEAS_PER_MIN = 60;
	localparam int MEAS_WINDOW  = 20;
	localparam int SPEED_MUL    = MEAS_PER_MIN / MEAS_WINDOW;
	localparam int PROD_W       = COUNT_WIDTH + 2;
	localparam int MEAS_W       = (PROD_W > KSPD_W) ? PROD_W : KSPD_W;

	typedef struct packed {
		logic req_type;
		logic knob_sel;
		logic b_level;
		logic system_running;
	} item_t;

	typedef struct packed {
		logic [VAL_W-1:0] temp_setpoint;
		logic [VAL_W-1:0] speed_setpoint;
		logic             setpoint_changed;
		logic [TGT_W-1:0] edit_target;
	} result_t;

	typedef struct packed {
		logic [THR_W-1:0] fast_threshold;
		logic [VAL_W-1:0] temp_ceil;
		logic [VAL_W-1:0] speed_ceil;
		logic [VAL_W-1:0] speed_start_value;
	} cfg_t;

	typedef struct packed {
		logic [VAL_W-1:0]                        temp_value;
		logic [VAL_W-1:0]                        speed_value;
		logic [NUM_KNOBS-1:0][COUNT_WIDTH-1:0]   edge_count;
		logic [NUM_KNOBS-1:0][KSPD_W-1:0]        knob_speed;
		logic [TGT_W-1:0]                        edit_mode;
	} state_t;

	function automatic logic [KSPD_W-1:0] meas_speed(input logic [COUNT_WIDTH-1:0] cnt);
		logic [MEAS_W-1:0] prod;
		prod = MEAS_W'(cnt) * MEAS_W'(SPEED_MUL);
		return (prod > MEAS_W'(SPEED_LIMIT)) ? SPEED_LIMIT : prod[KSPD_W-1:0];
	endfunction

endpackage
`default_nettype wire

[design/esa_if.sv]
// handshake channels: input items, result items and register writes
`default_nettype none
interface esa_in_if;
	logic valid;
	logic ready;
	logic req_type;
	logic knob_sel;
	logic b_level;
	logic system_running;

	modport source (output valid, output req_type, output knob_sel, output b_level,
		output system_running, input ready);
	modport sink (input valid, input req_type, input knob_sel, input b_level,
		input system_running, output ready);
endinterface

interface esa_out_if;
	logic                     valid;
	logic                     ready;
	logic [esa_pkg::VAL_W-1:0] temp_setpoint;
	logic [esa_pkg::VAL_W-1:0] speed_setpoint;
	logic                     setpoint_changed;
	logic [esa_pkg::TGT_W-1:0] edit_target;

	modport source (output valid, output temp_setpoint, output speed_setpoint,
		output setpoint_changed, output edit_target, input ready);
	modport sink (input valid, input temp_setpoint, input speed_setpoint,
		input setpoint_changed, input edit_target, output ready);
endinterface

interface esa_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [esa_pkg::CFG_IDX_W-1:0]  index;
	logic [esa_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[design/esa_cfg_regs.sv]
// configuration register bank
`default_nettype none
module esa_cfg_regs (
	input  wire              clk,
	input  wire              arst_n,
	esa_cfg_if.sink          cfg,
	output esa_pkg::cfg_t    regs
);
	import esa_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.fast_threshold    <= RST_FAST_THRESHOLD;
			regs_q.temp_ceil         <= RST_TEMP_MAX;
			regs_q.speed_ceil        <= RST_SPEED_MAX;
			regs_q.speed_start_value <= RST_SPEED_START_VALUE;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_FAST_THRESHOLD: begin
					regs_q.fast_threshold <= cfg.data[THR_W-1:0];
				end
				CFG_TEMP_MAX: begin
					regs_q.temp_ceil <= cfg.data[VAL_W-1:0];
				end
				CFG_SPEED_MAX: begin
					regs_q.speed_ceil <= cfg.data[VAL_W-1:0];
				end
				CFG_SPEED_START_VALUE: begin
					regs_q.speed_start_value <= cfg.data[VAL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end
endmodule
`default_nettype wire

[design/esa_update.sv]
// next-state and result logic for one knob edge or measurement tick
`default_nettype none
module esa_update (
	input  wire esa_pkg::state_t cur,
	input  wire esa_pkg::item_t  item,
	input  wire esa_pkg::cfg_t   regs,
	output esa_pkg::state_t  nxt,
	output esa_pkg::result_t res
);
	import esa_pkg::*;

	function automatic logic [VAL_W-1:0] adj_temp(input logic [VAL_W-1:0] v,
		input logic [STEP_W-1:0] step, input logic down, input logic [VAL_W-1:0] vmax);
		logic [VAL_W:0] sum;
		sum = {1'b0, v} + (VAL_W+1)'(step);
		if (down) begin
			return (v <= VAL_W'(step)) ? '0 : v - VAL_W'(step);
		end
		return (sum > {1'b0, vmax}) ? vmax : sum[VAL_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] adj_speed(input logic [VAL_W-1:0] v,
		input logic [STEP_W-1:0] step, input logic down, input logic [VAL_W-1:0] vmax,
		input logic [VAL_W-1:0] vstart);
		logic [VAL_W:0]   sum;
		logic [VAL_W-1:0] diff;
		diff = v - VAL_W'(step);
		sum  = (v == '0) ? {1'b0, vstart} : {1'b0, v} + (VAL_W+1)'(step);
		if (down) begin
			if (v < VAL_W'(step)) begin
				return '0;
			end
			return (diff < vstart) ? '0 : diff;
		end
		return (sum > {1'b0, vmax}) ? vmax : sum[VAL_W-1:0];
	endfunction

	logic [STEP_W-1:0] step;
	logic              changed;

	// coarse step once the measured knob speed reaches the threshold
	assign step = (cur.knob_speed[item.knob_sel] < regs.fast_threshold) ?
		STEP_FINE : STEP_COARSE;

	always_comb begin
		nxt     = cur;
		changed = 1'b0;
		if (item.req_type == REQ_TICK) begin
			for (int k = 0; k < NUM_KNOBS; k++) begin
				nxt.knob_speed[k] = meas_speed(cur.edge_count[k]);
				nxt.edge_count[k] = '0;
			end
		end else begin
			if (cur.edge_count[item.knob_sel] != COUNT_MAX) begin
				nxt.edge_count[item.knob_sel] = cur.edge_count[item.knob_sel] +
					COUNT_WIDTH'(1);
			end
			// running system only counts edges
			if (!item.system_running) begin
				changed = 1'b1;
				if (item.knob_sel == KNOB_TEMP) begin
					nxt.edit_mode  = EDIT_TEMP;
					nxt.temp_value = adj_temp(cur.temp_value, step, item.b_level,
						regs.temp_ceil);
				end else begin
					nxt.edit_mode   = EDIT_SPEED;
					nxt.speed_value = adj_speed(cur.speed_value, step, item.b_level,
						regs.speed_ceil, regs.speed_start_value);
				end
			end
		end
	end

	assign res.temp_setpoint    = nxt.temp_value;
	assign res.speed_setpoint   = nxt.speed_value;
	assign res.setpoint_changed = changed;
	assign res.edit_target      = nxt.edit_mode;
endmodule
`default_nettype wire

[design/encoder_setpoint_accelerator_unit.sv]
// path: an accepted item waits in the input register, then moves to the result register once that is free
// throughput: one item per cycle while results are taken; the setpoint state updates at the result register load
// a held result does not block at once: an empty input register still takes an item while it waits
// stall: input ready drops only when both registers are full and the result is not taken
// reset: arst_n clears setpoints, edge counts, knob speeds, edit target and both valids,
// and loads the configuration registers with their defaults
`default_nettype none
module encoder_setpoint_accelerator_unit (
	input  wire      clk,
	input  wire      arst_n,
	esa_in_if.sink   item_in,
	esa_out_if.source result_out,
	esa_cfg_if.sink  cfg
);
	import esa_pkg::*;

	cfg_t    regs;
	state_t  state_q;
	state_t  state_nxt;
	item_t   item_s1;
	result_t res_nxt;
	result_t res_q;
	logic    valid_s1;
	logic    out_valid_q;
	logic    advance;
	logic    fire_s1;
	logic    take_in;

	esa_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	esa_update u_update (
		.cur  (state_q),
		.item (item_s1),
		.regs (regs),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	assign advance       = !out_valid_q || result_out.ready;
	assign fire_s1       = valid_s1 && advance;
	assign item_in.ready = !valid_s1 || advance;
	assign take_in       = item_in.valid && item_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
			if (fire_s1) begin
				out_valid_q <= 1'b1;
				state_q     <= state_nxt;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.req_type       <= item_in.req_type;
			item_s1.knob_sel       <= item_in.knob_sel;
			item_s1.b_level        <= item_in.b_level;
			item_s1.system_running <= item_in.system_running;
		end
		if (fire_s1) begin
			res_q <= res_nxt;
		end
	end

	assign result_out.valid            = out_valid_q;
	assign result_out.temp_setpoint    = res_q.temp_setpoint;
	assign result_out.speed_setpoint   = res_q.speed_setpoint;
	assign result_out.setpoint_changed = res_q.setpoint_changed;
	assign result_out.edit_target      = res_q.edit_target;

	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |=> out_valid_q)
		else $error("processed item did not reach the result register");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item_in.ready |-> (valid_s1 && out_valid_q && !result_out.ready))
		else $error("input stalled without a full pipeline");

	a_change_has_target: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.setpoint_changed) |-> (res_q.edit_target != EDIT_NONE))
		else $error("setpoint change without edit target");

	a_tick_clears_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && item_s1.req_type == REQ_TICK) |=> (state_q.edge_count == '0))
		else $error("tick left edge counts");

	a_running_holds_temp: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && item_s1.req_type == REQ_EDGE && item_s1.system_running)
		|=> $stable(state_q.temp_value))
		else $error("temperature edited while running");
endmodule
`default_nettype wire
